@@ src/mck_pkg.sv @@
`timescale 1ns / 1ps
package mck_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned CountW = 18;
  localparam logic [UnitW-1:0] UnitTicksReset = 16'd1000;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CHAR = 2'd1;
  localparam logic [1:0] REQ_SOS  = 2'd2;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_J = 8'h4a;
  localparam logic [7:0] CHAR_K = 8'h4b;
  localparam logic [7:0] CHAR_O = 8'h4f;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_U = 8'h55;
  localparam logic [7:0] CHAR_Z = 8'h5a;
  localparam logic [7:0] CHAR_LC_A = 8'h61;
  localparam logic [7:0] CHAR_LC_Z = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CHAR_NONE = 8'h00;

  typedef struct packed {
    logic [3:0] pat;
    logic [2:0] len;
  } letter_t;

  typedef struct packed {
    logic       line_on;
    logic [3:0] line_index;
    logic       busy_res;
    logic       accepted;
  } res_t;

  // element pattern, next element in bit 0, 1 dash
  function automatic letter_t letter_lookup(input logic [7:0] c);
    letter_t l;
    case (c)
      CHAR_A:  l = '{pat: 4'd2,  len: 3'd2};
      CHAR_B:  l = '{pat: 4'd1,  len: 3'd4};
      CHAR_C:  l = '{pat: 4'd5,  len: 3'd4};
      CHAR_G:  l = '{pat: 4'd3,  len: 3'd3};
      CHAR_J:  l = '{pat: 4'd14, len: 3'd4};
      CHAR_K:  l = '{pat: 4'd5,  len: 3'd3};
      CHAR_R:  l = '{pat: 4'd2,  len: 3'd3};
      CHAR_U:  l = '{pat: 4'd4,  len: 3'd3};
      CHAR_Z:  l = '{pat: 4'd3,  len: 3'd4};
      CHAR_S:  l = '{pat: 4'd0,  len: 3'd3};
      CHAR_O:  l = '{pat: 4'd7,  len: 3'd3};
      default: l = '{pat: 4'd0,  len: 3'd0};
    endcase
    return l;
  endfunction

endpackage

@@ src/mck_if.sv @@
`timescale 1ns / 1ps
interface mck_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;
  logic [3:0] line_select;

  modport source (output valid, output req_type, output char_code, output line_select,
                  input ready);
  modport sink (input valid, input req_type, input char_code, input line_select,
                output ready);
endinterface

interface mck_res_if;
  logic       valid;
  logic       ready;
  logic       line_on;
  logic [3:0] line_index;
  logic       busy_res;
  logic       accepted;

  modport source (output valid, output line_on, output line_index, output busy_res,
                  output accepted, input ready);
  modport sink (input valid, input line_on, input line_index, input busy_res,
                input accepted, output ready);
endinterface

@@ src/mck_core.sv @@
`timescale 1ns / 1ps
module mck_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [mck_pkg::UnitW-1:0] cfg_wr_data,
  input  logic                      step,
  input  logic [1:0]                req_type,
  input  logic [7:0]                char_code,
  input  logic [3:0]                line_select,
  output mck_pkg::res_t             res
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MARK  = 2'd1;
  localparam logic [1:0] PH_SPACE = 2'd2;
  localparam logic [1:0] PH_GAP   = 2'd3;

  logic [mck_pkg::UnitW-1:0]  unit_ticks;
  logic [1:0]                 phase, phase_next;
  logic [mck_pkg::CountW-1:0] unit_counter, unit_counter_next;
  logic [3:0]                 element_pattern, element_pattern_next;
  logic [2:0]                 elements_left, elements_left_next;
  logic [1:0]                 sos_letter_count, sos_letter_count_next;
  logic [3:0]                 latched_line, latched_line_next;

  logic [mck_pkg::CountW-1:0] unit1, unit2, unit3, cnt_dec;
  logic [mck_pkg::UnitW-1:0]  unit_len;
  logic [7:0]                 ch_up, ch_sel;
  logic                       is_start, load, do_next, acc;
  mck_pkg::letter_t           ltr;
  logic [3:0]                 pat_src;
  logic [2:0]                 len_src;

  assign unit_len = (unit_ticks == '0) ? mck_pkg::UnitW'(1) : unit_ticks;
  assign unit1 = mck_pkg::CountW'(unit_len);
  assign unit2 = {1'b0, unit_len, 1'b0};
  assign unit3 = unit1 + unit2;
  assign cnt_dec = unit_counter - mck_pkg::CountW'(1);
  assign is_start = (req_type == mck_pkg::REQ_CHAR) || (req_type == mck_pkg::REQ_SOS);

  // fold lower case, and keep S and O for the distress sequence only
  always_comb begin
    ch_up = char_code;
    if (char_code >= mck_pkg::CHAR_LC_A && char_code <= mck_pkg::CHAR_LC_Z) begin
      ch_up = char_code - mck_pkg::CASE_OFFSET;
    end
    if (ch_up == mck_pkg::CHAR_S || ch_up == mck_pkg::CHAR_O) begin
      ch_up = mck_pkg::CHAR_NONE;
    end
  end

  always_comb begin
    phase_next = phase;
    unit_counter_next = unit_counter;
    element_pattern_next = element_pattern;
    elements_left_next = elements_left;
    sos_letter_count_next = sos_letter_count;
    latched_line_next = latched_line;
    acc = 1'b0;
    load = 1'b0;
    do_next = 1'b0;
    ch_sel = ch_up;

    if (is_start) begin
      if (phase == PH_IDLE) begin
        acc = 1'b1;
        latched_line_next = line_select;
        load = 1'b1;
        do_next = 1'b1;
        if (req_type == mck_pkg::REQ_CHAR) begin
          sos_letter_count_next = 2'd0;
        end else begin
          ch_sel = mck_pkg::CHAR_S;
          sos_letter_count_next = 2'd2;
        end
      end
    end else if (phase != PH_IDLE) begin
      unit_counter_next = cnt_dec;
      if (cnt_dec == '0) begin
        case (phase)
          PH_MARK: begin
            phase_next = PH_SPACE;
            unit_counter_next = unit1;
          end
          PH_SPACE: begin
            do_next = 1'b1;
          end
          PH_GAP: begin
            if (sos_letter_count != 2'd0) begin
              ch_sel = (sos_letter_count == 2'd2) ? mck_pkg::CHAR_O : mck_pkg::CHAR_S;
              sos_letter_count_next = sos_letter_count - 2'd1;
              load = 1'b1;
              do_next = 1'b1;
            end else begin
              phase_next = PH_IDLE;
              element_pattern_next = 4'd0;
              elements_left_next = 3'd0;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end

    ltr = mck_pkg::letter_lookup(ch_sel);
    pat_src = load ? ltr.pat : element_pattern;
    len_src = load ? ltr.len : elements_left;

    // start the next element, or the character gap when none are left
    if (do_next) begin
      if (len_src != 3'd0) begin
        element_pattern_next = {1'b0, pat_src[3:1]};
        elements_left_next = len_src - 3'd1;
        phase_next = PH_MARK;
        unit_counter_next = pat_src[0] ? unit3 : unit1;
      end else begin
        element_pattern_next = pat_src;
        elements_left_next = len_src;
        phase_next = PH_GAP;
        unit_counter_next = unit2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= mck_pkg::UnitTicksReset;
      phase <= PH_IDLE;
      unit_counter <= '0;
      element_pattern <= '0;
      elements_left <= '0;
      sos_letter_count <= '0;
      latched_line <= '0;
    end else begin
      if (cfg_wr_en) begin
        unit_ticks <= cfg_wr_data;
      end
      if (step) begin
        phase <= phase_next;
        unit_counter <= unit_counter_next;
        element_pattern <= element_pattern_next;
        elements_left <= elements_left_next;
        sos_letter_count <= sos_letter_count_next;
        latched_line <= latched_line_next;
      end
    end
  end

  assign res.line_on = (phase_next == PH_MARK);
  assign res.line_index = latched_line_next;
  assign res.busy_res = (phase_next != PH_IDLE);
  assign res.accepted = acc;

endmodule

@@ src/mck_out_buf.sv @@
`timescale 1ns / 1ps
module mck_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mck_pkg::res_t push_data,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mck_pkg::res_t pop_data
);

  mck_pkg::res_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          pop;

  assign full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop = pop_valid && pop_ready;
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/morse_character_keyer.sv @@
`timescale 1ns / 1ps
// morse keyer for one character or one distress sequence at a time
// req channel: one beat per request, req_type tick, start character or
//   start distress sequence, with the ascii code and the line to key
// res channel: exactly one beat per request beat, giving the line level,
//   the latched line index, busy and whether a start was taken
// cfg_wr_en / cfg_wr_data write unit_ticks, the ticks in one time unit;
//   write it only while nothing is in flight
// result: each result beat waits in the result queue behind older ones
// throughput: one request per cycle while the queue has room; the state
//   update is a single pass of logic from keyer registers to the queue
// a start while busy is ignored and reported with accepted low
// reset: idle, line index 0, unit_ticks 1000, result queue empty
// stall: a two-beat result queue keeps taking requests while a result
//   waits; req ready drops only when both queue entries are held
module morse_character_keyer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [mck_pkg::UnitW-1:0] cfg_wr_data,
  mck_req_if.sink                   req,
  mck_res_if.source                 res
);

  logic          full;
  logic          step;
  mck_pkg::res_t core_res;
  mck_pkg::res_t out_res;

  assign req.ready = ~full;
  assign step = req.valid && ~full;

  mck_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .req_type    (req.req_type),
    .char_code   (req.char_code),
    .line_select (req.line_select),
    .res         (core_res)
  );

  mck_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (core_res),
    .full      (full),
    .pop_valid (res.valid),
    .pop_ready (res.ready),
    .pop_data  (out_res)
  );

  assign res.line_on = out_res.line_on;
  assign res.line_index = out_res.line_index;
  assign res.busy_res = out_res.busy_res;
  assign res.accepted = out_res.accepted;

endmodule
